// ----- src/psrl_pkg.sv -----
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants of the per-source rate limiter
// Transaction payloads, table entry layout, register indexes, reset values
// and the sequencer state encoding.
// ----------------------------------------------------------------------------
package psrl_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int TIME_W     = 63;
    localparam int ADDR_W     = 32;
    localparam int BURST_W    = 8;
    localparam int COUNT_W    = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_WINDOW = 2'd2;

    // register reset values
    localparam logic [31:0]        RST_MIN_INTERVAL = 32'd2000000;
    localparam logic [BURST_W-1:0] RST_BURST_LIMIT  = 8'd3;
    localparam logic [31:0]        RST_BURST_WINDOW = 32'd10000000;

    localparam logic [BURST_W-1:0] BURST_MAX = 8'hFF;

    typedef struct packed {
        logic [ADDR_W-1:0] client_ip;
        logic [TIME_W-1:0] now_us;
    } t_query;

    typedef struct packed {
        logic               allowed;
        logic [COUNT_W-1:0] total_served;
        logic [COUNT_W-1:0] total_dropped;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [TIME_W-1:0]  last_accept;
        logic [BURST_W-1:0] burst_tally;
        logic [TIME_W-1:0]  window_start;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEW,
        S_CALC_BURST,
        S_EXPIRE,
        S_CALC_LAST,
        S_DECIDE,
        S_WRITE
    } t_state;

endpackage

// ----- src/per_source_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// per_source_rate_limiter: per-source query rate limiter with burst allowance
// A query scans the table through the RAM read port, one slot per cycle, until
// it hits the source or has read every slot in use; a known source then runs
// the burst and interval steps, an unknown one takes a free or the oldest slot.
// busy falls in the o_done cycle, so the next start may be taken there.
// The receiver cannot stall. Reset clears the fill count and totals and loads
// the registers with their reset values.
// ----------------------------------------------------------------------------
module per_source_rate_limiter #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // query transaction
    input  logic                                   start,
    output logic                                   busy,
    input  psrl_pkg::t_query                       i_query,
    // result transaction, one-cycle strobe
    output logic                                   o_done,
    output psrl_pkg::t_result                      o_result,
    // register write port
    input  logic                                   i_cfg_we,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    import psrl_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

    // configuration
    logic [31:0]        r_min_interval;
    logic [BURST_W-1:0] r_burst_limit;
    logic [31:0]        r_burst_window;

    // sequencer and working registers
    t_state             r_state, n_state;
    t_query             r_q;
    logic [CNT_W-1:0]   r_idx;       // next slot to read
    logic               r_pend;      // read data of slot r_pidx arrives now
    logic [IDX_W-1:0]   r_pidx;
    logic [TIME_W-1:0]  r_best;      // oldest last-accepted time seen
    logic [IDX_W-1:0]   r_best_idx;
    logic [IDX_W-1:0]   r_slot;
    t_entry             r_ent;
    logic [TIME_W:0]    r_diff;      // signed 64-bit time difference
    logic               r_allow;
    logic [CNT_W-1:0]   r_used;
    logic [COUNT_W-1:0] r_served;
    logic [COUNT_W-1:0] r_dropped;
    t_result            r_res;
    logic               r_done;

    // table RAM
    logic               ram_re;
    logic               ram_we;
    t_entry             ram_rdata;

    // shared subtractor
    logic [TIME_W:0]    sub_a, sub_b, sub_y;

    logic               issue;
    logic               hit;
    logic               full;
    logic               expired;
    logic               interval_ok;
    logic [BURST_W-1:0] cnt_base;

    psrl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_ent),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign full  = (r_used == FULL);
    assign hit   = r_pend && (ram_rdata.address == r_q.client_ip);
    assign issue = (r_idx < r_used) && !hit;

    assign sub_y = sub_a - sub_b;

    // Expiry and interval tests on the registered difference: a negative
    // difference fails both.
    assign expired     = !r_diff[TIME_W] &&
                         (r_diff[TIME_W-1:0] > {31'b0, r_burst_window});
    assign interval_ok = !r_diff[TIME_W] &&
                         (r_diff[TIME_W-1:0] >= {31'b0, r_min_interval});
    assign cnt_base    = expired ? '0 : r_ent.burst_tally;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit)         n_state = S_CALC_BURST;
                else if (!issue) n_state = S_NEW;
            end
            S_NEW:        n_state = S_WRITE;
            S_CALC_BURST: n_state = S_EXPIRE;
            S_EXPIRE:     n_state = S_CALC_LAST;
            S_CALC_LAST:  n_state = S_DECIDE;
            S_DECIDE:     n_state = S_WRITE;
            S_WRITE:      n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------- control outputs
    always_comb begin
        ram_re = 1'b0;
        ram_we = 1'b0;
        sub_a  = '0;
        sub_b  = '0;
        case (r_state)
            S_SCAN: begin
                // candidate minus current oldest: negative means older
                ram_re = issue;
                sub_a  = {1'b0, ram_rdata.last_accept};
                sub_b  = {1'b0, r_best};
            end
            S_CALC_BURST: begin
                sub_a = {1'b0, r_q.now_us};
                sub_b = {1'b0, r_ent.window_start};
            end
            S_CALC_LAST: begin
                sub_a = {1'b0, r_q.now_us};
                sub_b = {1'b0, r_ent.last_accept};
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // ----------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_used         <= '0;
            r_served       <= '0;
            r_dropped      <= '0;
            r_done         <= 1'b0;
            r_pend         <= 1'b0;
            r_min_interval <= RST_MIN_INTERVAL;
            r_burst_limit  <= RST_BURST_LIMIT;
            r_burst_window <= RST_BURST_WINDOW;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;

            // register writes; unknown indexes drop
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                    CFG_BURST_LIMIT:  r_burst_limit  <= i_cfg_data[BURST_W-1:0];
                    CFG_BURST_WINDOW: r_burst_window <= i_cfg_data;
                    default:          r_burst_limit  <= r_burst_limit;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    // latch the query and restart the scan
                    r_q    <= i_query;
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                end
                S_SCAN: begin
                    r_pend <= issue;
                    r_pidx <= r_idx[IDX_W-1:0];
                    if (issue) r_idx <= r_idx + 1'b1;
                    if (hit) begin
                        r_slot <= r_pidx;
                        r_ent  <= ram_rdata;
                    end else if (r_pend) begin
                        // track the oldest entry, lowest index on ties
                        if ((r_pidx == '0) || sub_y[TIME_W]) begin
                            r_best     <= ram_rdata.last_accept;
                            r_best_idx <= r_pidx;
                        end
                    end
                end
                S_NEW: begin
                    // take a free slot, or evict the oldest one
                    if (full) begin
                        r_slot <= r_best_idx;
                    end else begin
                        r_slot <= r_used[IDX_W-1:0];
                        r_used <= r_used + 1'b1;
                    end
                    r_ent.address      <= r_q.client_ip;
                    r_ent.last_accept  <= r_q.now_us;
                    r_ent.burst_tally  <= BURST_W'(1);
                    r_ent.window_start <= r_q.now_us;
                    r_allow            <= 1'b1;
                end
                S_CALC_BURST: begin
                    r_diff <= sub_y;
                end
                S_EXPIRE: begin
                    // restart an expired burst, then count this query
                    if (expired) r_ent.window_start <= r_q.now_us;
                    r_ent.burst_tally <= (cnt_base == BURST_MAX) ?
                                         BURST_MAX : cnt_base + 1'b1;
                end
                S_CALC_LAST: begin
                    r_diff <= sub_y;
                end
                S_DECIDE: begin
                    if (interval_ok || (r_ent.burst_tally <= r_burst_limit)) begin
                        r_allow           <= 1'b1;
                        r_ent.last_accept <= r_q.now_us;
                    end else begin
                        r_allow <= 1'b0;
                    end
                end
                S_WRITE: begin
                    // advance the totals and present the result transaction
                    r_done          <= 1'b1;
                    r_res.allowed   <= r_allow;
                    if (r_allow) begin
                        r_served            <= r_served + 1'b1;
                        r_res.total_served  <= r_served + 1'b1;
                        r_res.total_dropped <= r_dropped;
                    end else begin
                        r_dropped           <= r_dropped + 1'b1;
                        r_res.total_served  <= r_served;
                        r_res.total_dropped <= r_dropped + 1'b1;
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- src/psrl_ram.sv -----
// ----------------------------------------------------------------------------
// psrl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// data holds while the read enable is low.
// ----------------------------------------------------------------------------
module psrl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- verif/psrl_verdict_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psrl_verdict_checker: allow/drop predictor and result scoreboard
// Watches the query, result and register channels of the rate limiter, keeps
// its own source table and totals, and compares every result strobe against
// the oldest predicted verdict.
// ----------------------------------------------------------------------------
module psrl_verdict_checker #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  psrl_pkg::t_query                i_query,
    input  logic                            i_done,
    input  psrl_pkg::t_result               i_result,
    input  logic                            i_cfg_we,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    import psrl_pkg::*;

    t_entry                source_table [TABLE_ENTRIES];
    int unsigned           sources_held;
    logic [COUNT_W-1:0]    served_total;
    logic [COUNT_W-1:0]    dropped_total;
    logic [31:0]           gap_limit;
    logic [BURST_W-1:0]    burst_limit;
    logic [31:0]           burst_window;
    t_result               expected_verdicts [$];
    int                    mismatches = 0;
    int                    outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // Exact signed difference of two 63-bit times.
    function automatic longint elapsed_us(input logic [TIME_W-1:0] later,
                                          input logic [TIME_W-1:0] earlier);
        longint a;
        longint b;
        a = {1'b0, later};
        b = {1'b0, earlier};
        return a - b;
    endfunction

    task automatic judge_query(input t_query q);
        int     slot;
        bit     found;
        bit     allow;
        longint since_accept;
        longint interval_lim;
        longint window_lim;
        slot         = 0;
        found        = 1'b0;
        interval_lim = {32'd0, gap_limit};
        window_lim   = {32'd0, burst_window};
        for (int i = 0; i < sources_held; i++) begin
            if (!found && source_table[i].address == q.client_ip) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (sources_held < TABLE_ENTRIES) begin
                slot = sources_held;
                sources_held++;
            end else begin
                // evict the stalest last-accept, lowest slot on ties
                for (int i = 1; i < TABLE_ENTRIES; i++) begin
                    if (source_table[i].last_accept < source_table[slot].last_accept)
                        slot = i;
                end
            end
            source_table[slot].address      = q.client_ip;
            source_table[slot].last_accept  = q.now_us;
            source_table[slot].burst_tally  = 8'd1;
            source_table[slot].window_start = q.now_us;
            allow = 1'b1;
        end else begin
            since_accept = elapsed_us(q.now_us, source_table[slot].last_accept);
            if (elapsed_us(q.now_us, source_table[slot].window_start) > window_lim) begin
                source_table[slot].burst_tally  = '0;
                source_table[slot].window_start = q.now_us;
            end
            if (source_table[slot].burst_tally != BURST_MAX)
                source_table[slot].burst_tally++;
            allow = (since_accept >= interval_lim) ||
                    (source_table[slot].burst_tally <= burst_limit);
            if (allow)
                source_table[slot].last_accept = q.now_us;
        end
        if (allow)
            served_total++;
        else
            dropped_total++;
        expected_verdicts.push_back({allow, served_total, dropped_total});
    endtask

    task automatic check_verdict(input t_result got);
        t_result exp_v;
        exp_v = expected_verdicts.pop_front();
        if (got.allowed !== exp_v.allowed) begin
            $error("allowed: expected %0d, got %0d", exp_v.allowed, got.allowed);
            mismatches++;
        end
        if (got.total_served !== exp_v.total_served) begin
            $error("total_served: expected %0d, got %0d",
                   exp_v.total_served, got.total_served);
            mismatches++;
        end
        if (got.total_dropped !== exp_v.total_dropped) begin
            $error("total_dropped: expected %0d, got %0d",
                   exp_v.total_dropped, got.total_dropped);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sources_held  = 0;
            served_total  = '0;
            dropped_total = '0;
            gap_limit     = RST_MIN_INTERVAL;
            burst_limit   = RST_BURST_LIMIT;
            burst_window  = RST_BURST_WINDOW;
            expected_verdicts.delete();
        end else begin
            // compare before predicting: a result and a new query share edges
            if (i_done) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result strobe with no query outstanding");
                    mismatches++;
                end else begin
                    check_verdict(i_result);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_INTERVAL: gap_limit    = i_cfg_data;
                    CFG_BURST_LIMIT:  burst_limit  = i_cfg_data[BURST_W-1:0];
                    CFG_BURST_WINDOW: burst_window = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                judge_query(i_query);
        end
        outstanding = expected_verdicts.size();
    end

endmodule

// ----- verif/tb_per_source_rate_limiter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_source_rate_limiter: stimulus and verdict for the rate limiter
// Runs a directed query sequence on the reset limits, then random phases with
// extreme and random limits, a long single-source run that pins the burst
// counter, and table-filling traffic; a side checker predicts every verdict.
// ----------------------------------------------------------------------------
module tb_per_source_rate_limiter;

    import psrl_pkg::*;

    localparam int                   TABLE_ENTRIES = 32;
    localparam int                   STALL_LIMIT   = 2000;
    localparam int                   PHASE_QUERIES = 20;
    localparam int                   PIN_QUERIES   = 262;
    localparam int                   POOL_SIZE     = 64;
    // index past the last register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED  = 2'd3;
    localparam logic [TIME_W-1:0]    TIME_MAX      = {TIME_W{1'b1}};

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_query                i_query    = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int                    mismatches;
    int                    outstanding;
    int                    stall_cycles = 0;
    bit                    steady = 1'b0;
    logic [TIME_W-1:0]     wall_us;
    logic [ADDR_W-1:0]     source_pool [POOL_SIZE];

    per_source_rate_limiter #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_query    (i_query),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    psrl_verdict_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_query       (i_query),
        .i_done        (o_done),
        .i_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort when neither a query nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one query and hold it until the block takes it. Start stays high
    // across back-to-back queries; drop it only for an idle gap.
    task automatic send_query(input logic [ADDR_W-1:0] ip, input logic [TIME_W-1:0] t);
        if (!steady && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_query <= '{client_ip: ip, now_us: t};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Release start and wait until every verdict has come back. Sample on
    // the falling edge so the checker's count is settled.
    task automatic drain;
        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    // Drain, then write all three limits plus the unmapped index. Upper bits
    // of the burst limit word carry junk that the block must drop.
    task automatic program_limits(input logic [31:0] gap_limit,
                                  input logic [BURST_W-1:0] limit,
                                  input logic [31:0] window);
        logic [31:0] junk;
        junk = $urandom;
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_INTERVAL;
        i_cfg_data <= gap_limit;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BURST_LIMIT;
        i_cfg_data <= {junk[31:BURST_W], limit};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BURST_WINDOW;
        i_cfg_data <= window;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNMAPPED;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_limit_word();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 4000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return BURST_MAX;
            2:       return BURST_W'($urandom_range(1, 6));
            default: return BURST_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Move the clock mostly forward at several scales; now and then step
    // back or jump anywhere in the 63-bit range.
    task automatic advance_wall();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            wall_us = wall_us;
        else if (roll < 55)
            wall_us = wall_us + TIME_W'($urandom_range(0, 1000));
        else if (roll < 85)
            wall_us = wall_us + TIME_W'($urandom_range(0, 3000000));
        else if (roll < 93)
            wall_us = wall_us + TIME_W'($urandom);
        else if (roll < 96)
            wall_us = wall_us - TIME_W'($urandom_range(1, 5000000));
        else
            wall_us = TIME_W'({$urandom, $urandom});
    endtask

    // Draw sources from a pool slice; a slice wider than the table forces
    // eviction, a narrow one keeps hitting known sources.
    task automatic random_phase(input int span);
        logic [ADDR_W-1:0] ip;
        for (int n = 0; n < PHASE_QUERIES; n++) begin
            advance_wall();
            if ($urandom_range(9) == 0)
                ip = $urandom;
            else
                ip = source_pool[$urandom_range(0, span - 1)];
            send_query(ip, wall_us);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] pinned_ip;

        source_pool[0] = '0;
        source_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            source_pool[i] = $urandom;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset limits (2 s interval, burst of 3, 10 s window).
        send_query(32'h0, 63'd0);              // new source, always served
        send_query(32'h0, 63'd1);              // inside burst
        send_query(32'h0, 63'd2);              // burst limit reached exactly
        send_query(32'h0, 63'd3);              // over burst, interval short: drop
        send_query(32'h0, 63'd2000002);        // interval met exactly
        send_query(32'hFFFF_FFFF, 63'd2000002);
        send_query(32'hFFFF_FFFF, 63'd12000002); // window age equal: no restart
        send_query(32'hFFFF_FFFF, 63'd12000003); // window expired: restart
        send_query(32'h0, 63'd10000001);
        // time running backwards: negative ages never pass or expire
        repeat (4) send_query(32'h0, 63'd5);
        send_query(32'h0, TIME_MAX);
        send_query(32'h0, 63'd0);
        send_query(32'hFFFF_FFFF, TIME_MAX);

        wall_us = 63'd20000000;

        // Extreme limits, zero burst limit included.
        program_limits(32'd0, 8'd0, 32'd0);
        random_phase(16);
        program_limits(32'hFFFF_FFFF, BURST_MAX, 32'hFFFF_FFFF);
        random_phase(POOL_SIZE);
        program_limits(32'hFFFF_FFFF, 8'd0, 32'd0);
        random_phase(40);

        // Pin one source's burst counter at its ceiling: long window, a limit
        // well below 255, no idle gaps.
        program_limits(32'hFFFF_FFFF, BURST_W'($urandom_range(1, 20)), 32'hFFFF_FFFF);
        steady    = 1'b1;
        pinned_ip = $urandom;
        for (int n = 0; n < PIN_QUERIES; n++) begin
            wall_us = wall_us + TIME_W'($urandom_range(0, 50));
            send_query(pinned_ip, wall_us);
        end
        steady = 1'b0;

        program_limits(pick_limit_word(), pick_burst(), pick_limit_word());
        random_phase(4);
        program_limits(pick_limit_word(), pick_burst(), pick_limit_word());
        random_phase(POOL_SIZE);
        program_limits(RST_MIN_INTERVAL, RST_BURST_LIMIT, RST_BURST_WINDOW);
        random_phase(40);

        drain();
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/psrl_pkg.sv
src/psrl_ram.sv
src/per_source_rate_limiter.sv
verif/psrl_verdict_checker.sv
verif/tb_per_source_rate_limiter.sv
